// File: rtl/wmv_pkg.sv
// ----------------------------------------------------------------------------
// wmv_pkg
// Shared field widths, the controller state type and the command and status
// bundles that pass between the vote controller and its datapath.
// ----------------------------------------------------------------------------
package wmv_pkg;

  localparam int DEV_W   = 1;
  localparam int OBJ_W   = 6;
  localparam int LVL_W   = 3;
  localparam int WSIZE_W = 5;

  localparam logic [WSIZE_W-1:0] WSIZE_RST = 5'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_UPDATE,
    ST_COUNT,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic clr_en;
    logic latch_in;
    logic meta_rd;
    logic update;
    logic issue_rd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic issue_last;
    logic out_busy;
  } dp_status_t;

endpackage

// File: rtl/wmv_if.sv
// ----------------------------------------------------------------------------
// wmv_if
// Valid/ready channels of the vote block: configuration, input and result.
// ----------------------------------------------------------------------------
interface wmv_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wmv_pkg::WSIZE_W-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

interface wmv_in_if;
  logic                      valid;
  logic                      ready;
  logic [wmv_pkg::DEV_W-1:0] device_index;
  logic [wmv_pkg::OBJ_W-1:0] object_slot;
  logic [wmv_pkg::LVL_W-1:0] predicted_level;

  modport source (output valid, output device_index, output object_slot,
                  output predicted_level, input ready);
  modport sink   (input valid, input device_index, input object_slot,
                  input predicted_level, output ready);
endinterface

interface wmv_out_if;
  logic                      valid;
  logic                      ready;
  logic [wmv_pkg::LVL_W-1:0] voted_level;

  modport source (output valid, output voted_level, input ready);
  modport sink   (input valid, input voted_level, output ready);
endinterface

// File: rtl/wmv_ctrl.sv
// ----------------------------------------------------------------------------
// wmv_ctrl
// Sequencer for the vote: clearing pass, item intake, history update,
// counting sweep and result hand-off.
// ----------------------------------------------------------------------------
module wmv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wmv_pkg::dp_status_t status_i,
  output wmv_pkg::dp_cmd_t    cmd_o
);

  wmv_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmv_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wmv_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) state_d = wmv_pkg::ST_IDLE;
      end
      wmv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = wmv_pkg::ST_META;
        end
      end
      wmv_pkg::ST_META: begin
        cmd_o.meta_rd = 1'b1;
        state_d       = wmv_pkg::ST_UPDATE;
      end
      wmv_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = wmv_pkg::ST_COUNT;
      end
      wmv_pkg::ST_COUNT: begin
        cmd_o.issue_rd = 1'b1;
        if (status_i.issue_last) state_d = wmv_pkg::ST_DRAIN;
      end
      wmv_pkg::ST_DRAIN: begin
        // The last history entry is counted during this cycle.
        state_d = wmv_pkg::ST_FINISH;
      end
      wmv_pkg::ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = wmv_pkg::ST_IDLE;
        end
      end
    endcase
  end

endmodule

// File: rtl/wmv_dp.sv
// ----------------------------------------------------------------------------
// wmv_dp
// Datapath of the vote: window register, per-pair ring metadata memory,
// history memory, level counters with a running winner, output register.
// ----------------------------------------------------------------------------
module wmv_dp #(
  parameter int NUM_LEVELS  = 5,
  parameter int MAX_WINDOW  = 16,
  parameter int NUM_OBJECTS = 64,
  parameter int NUM_DEVICES = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wmv_pkg::dp_cmd_t            cmd_i,
  output wmv_pkg::dp_status_t         status_o,
  input  logic                        cfg_valid_i,
  input  logic [wmv_pkg::WSIZE_W-1:0] cfg_window_size_i,
  input  logic [wmv_pkg::DEV_W-1:0]   device_index_i,
  input  logic [wmv_pkg::OBJ_W-1:0]   object_slot_i,
  input  logic [wmv_pkg::LVL_W-1:0]   predicted_level_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [wmv_pkg::LVL_W-1:0]   voted_level_o
);

  localparam int OBJ_W   = wmv_pkg::OBJ_W;
  localparam int LVL_W   = wmv_pkg::LVL_W;
  localparam int WSIZE_W = wmv_pkg::WSIZE_W;
  localparam int NOBJ_IN = 2 ** OBJ_W;
  localparam int PAIRS   = NUM_DEVICES * NUM_OBJECTS;
  localparam int PAIR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int HDEPTH  = PAIRS * MAX_WINDOW;
  localparam int HADDR_W = $clog2(HDEPTH);
  localparam int POS_W   = $clog2(MAX_WINDOW);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int META_W  = POS_W + WIN_W;
  localparam int NCNT    = (NUM_LEVELS < 8) ? NUM_LEVELS : 8;
  localparam int CIDX_W  = $clog2(NCNT);
  localparam int CMP_W   = (WIN_W > WSIZE_W) ? WIN_W : WSIZE_W;

  // Window register and its clamped value.
  logic [WSIZE_W-1:0] wsize_q;
  logic [CMP_W-1:0]   wsize_ext;
  logic [WIN_W-1:0]   win_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= wmv_pkg::WSIZE_RST;
    end else if (cfg_valid_i) begin
      wsize_q <= cfg_window_size_i;
    end
  end

  always_comb begin
    wsize_ext = CMP_W'(wsize_q);
    if (wsize_ext > CMP_W'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else if (wsize_ext == '0) begin
      win_eff = WIN_W'(1);
    end else begin
      win_eff = WIN_W'(wsize_ext);
    end
  end

  // Input decode: object wrap table, pair index, level clamp.
  logic [OBJ_W-1:0]  obj_wrap [NOBJ_IN];
  logic [OBJ_W-1:0]  obj_w;
  logic              dev_hi;
  logic [PAIR_W-1:0] pair_d;
  logic [CIDX_W-1:0] lvl_d;

  for (genvar g = 0; g < NOBJ_IN; g++) begin : g_wrap
    assign obj_wrap[g] = OBJ_W'(g % NUM_OBJECTS);
  end

  assign obj_w  = obj_wrap[object_slot_i];
  assign dev_hi = (NUM_DEVICES > 1) && device_index_i[0];
  assign pair_d = (dev_hi ? PAIR_W'(NUM_OBJECTS) : PAIR_W'(0)) + PAIR_W'(obj_w);

  always_comb begin
    if ((WSIZE_W'(predicted_level_i)) >= WSIZE_W'(NCNT)) begin
      lvl_d = CIDX_W'(NCNT - 1);
    end else begin
      lvl_d = CIDX_W'(predicted_level_i);
    end
  end

  logic [PAIR_W-1:0]  pair_q;
  logic [CIDX_W-1:0]  lvl_q;
  logic [WIN_W-1:0]   win_q;
  logic [HADDR_W-1:0] hist_base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      pair_q <= pair_d;
      lvl_q  <= lvl_d;
      win_q  <= win_eff;
    end
    if (cmd_i.meta_rd) begin
      hist_base_q <= HADDR_W'(pair_q) * HADDR_W'(MAX_WINDOW);
    end
  end

  // Ring metadata: write position and fill count per pair. Zero means unused.
  logic [META_W-1:0] meta_mem [PAIRS];
  logic [META_W-1:0] meta_rd_q;
  logic [PAIR_W-1:0] clr_cnt_q;
  logic [POS_W-1:0]  pos_cur, pos_eff, pos_n;
  logic [WIN_W-1:0]  fill_cur, fill_n, pos_inc, n_d;

  assign pos_cur  = meta_rd_q[META_W-1:WIN_W];
  assign fill_cur = meta_rd_q[WIN_W-1:0];

  always_comb begin
    pos_eff = (WIN_W'(pos_cur) >= win_q) ? '0 : pos_cur;
    pos_inc = WIN_W'(pos_eff) + 1'b1;
    pos_n   = (pos_inc >= win_q) ? '0 : POS_W'(pos_inc);
    fill_n  = (fill_cur < win_q) ? fill_cur + 1'b1 : fill_cur;
    n_d     = (fill_n > win_q) ? win_q : fill_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      meta_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.update) begin
      meta_mem[pair_q] <= {pos_n, fill_n};
    end
    if (cmd_i.meta_rd) begin
      meta_rd_q <= meta_mem[pair_q];
    end
  end

  // History memory: one entry written per item, then swept one per cycle.
  logic [CIDX_W-1:0] hist_mem [HDEPTH];
  logic [CIDX_W-1:0] hist_rd_q;
  logic [POS_W-1:0]  idx_q;
  logic [WIN_W-1:0]  n_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hist_mem[hist_base_q + HADDR_W'(pos_eff)] <= lvl_q;
    end
    if (cmd_i.issue_rd) begin
      hist_rd_q <= hist_mem[hist_base_q + HADDR_W'(idx_q)];
    end
  end

  // Counters with a running winner: after each increment the winner is the
  // highest count, lowest level among equals, so no final search is needed.
  logic [WIN_W-1:0]  cnt_q [NCNT];
  logic [CIDX_W-1:0] best_q;
  logic [WIN_W-1:0]  best_cnt_q;
  logic [CIDX_W-1:0] rd_lvl;
  logic [WIN_W-1:0]  cnt_inc;

  assign rd_lvl  = ((CIDX_W + 1)'(hist_rd_q) >= (CIDX_W + 1)'(NCNT)) ?
                   CIDX_W'(NCNT - 1) : hist_rd_q;
  assign cnt_inc = cnt_q[rd_lvl] + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCNT; i++) cnt_q[i] <= '0;
      best_q     <= '0;
      best_cnt_q <= '0;
      idx_q      <= '0;
      n_q        <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue_rd;
      if (cmd_i.update) begin
        for (int i = 0; i < NCNT; i++) cnt_q[i] <= '0;
        best_q     <= '0;
        best_cnt_q <= '0;
        idx_q      <= '0;
        n_q        <= n_d;
      end else begin
        if (cmd_i.issue_rd) idx_q <= idx_q + 1'b1;
        if (rd_vld_q) begin
          cnt_q[rd_lvl] <= cnt_inc;
          if ((cnt_inc > best_cnt_q) || ((cnt_inc == best_cnt_q) && (rd_lvl < best_q))) begin
            best_q     <= rd_lvl;
            best_cnt_q <= cnt_inc;
          end
        end
      end
    end
  end

  // Output register decouples the result from the next item's work.
  logic             out_valid_q;
  logic [LVL_W-1:0] voted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) voted_q <= LVL_W'(best_q);
  end

  assign out_valid_o   = out_valid_q;
  assign voted_level_o = voted_q;

  assign status_o.clr_last   = (clr_cnt_q == PAIR_W'(PAIRS - 1));
  assign status_o.issue_last = (WIN_W'(idx_q) == (n_q - 1'b1));
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

// File: rtl/windowed_majority_vote_per_object.sv
// ----------------------------------------------------------------------------
// windowed_majority_vote_per_object
// Per-object sliding-window mode filter over predicted scale levels. Every
// input updates the ring of the last window_size levels kept for its
// device/object pair and returns the most frequent level in that ring, the
// lowest level winning a tie. One item is in work at a time. The result is
// loaded after the metadata read, the history update, the counting sweep over
// the n stored entries voted over (at most MAX_WINDOW) and a drain state, and
// the next input can be taken in the cycle after the result is loaded; the pace
// is set by the history memory's single read port, which sweeps one entry per
// cycle. The next item is taken while the result waits in the output register,
// but its own result is not loaded until that register is free. After reset a
// clearing pass over all NUM_DEVICES * NUM_OBJECTS metadata entries (128 by
// default) zeroes the ring metadata; no item is taken during it, while
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module windowed_majority_vote_per_object #(
  parameter int NUM_LEVELS  = 5,
  parameter int MAX_WINDOW  = 16,
  parameter int NUM_OBJECTS = 64,
  parameter int NUM_DEVICES = 2
) (
  input logic        clk_i,
  input logic        rst_ni,
  wmv_cfg_if.sink    cfg_i,
  wmv_in_if.sink     in_i,
  wmv_out_if.source  out_o
);

  wmv_pkg::dp_cmd_t    cmd;
  wmv_pkg::dp_status_t status;

  assign cfg_i.ready = 1'b1;

  wmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmv_dp #(
    .NUM_LEVELS  (NUM_LEVELS),
    .MAX_WINDOW  (MAX_WINDOW),
    .NUM_OBJECTS (NUM_OBJECTS),
    .NUM_DEVICES (NUM_DEVICES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_window_size_i (cfg_i.window_size),
    .device_index_i    (in_i.device_index),
    .object_slot_i     (in_i.object_slot),
    .predicted_level_i (in_i.predicted_level),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .voted_level_o     (out_o.voted_level)
  );

`ifndef SYNTHESIS
  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_en, cmd.latch_in, cmd.meta_rd, cmd.update, cmd.issue_rd,
              cmd.load_out}))
    else $error("datapath commands overlap");

  a_accept_reads_meta : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cmd.meta_rd)
    else $error("input transfer not followed by metadata read");

  a_update_then_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |=> cmd.issue_rd)
    else $error("history update not followed by the counting sweep");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_o.valid && !out_o.ready))
    else $error("result loaded over a result not yet transferred");
`endif

endmodule

// File: tb/mode_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mode_filter_checker
// Watches the configuration, observation and vote channels of the windowed
// majority vote block. Every observation transfer runs through a local ring
// model of its device/object pair. The predicted vote is queued, and each
// vote transfer is compared against the oldest queued prediction.
// ----------------------------------------------------------------------------
module mode_filter_checker #(
  parameter int NUM_LEVELS  = 5,
  parameter int MAX_WINDOW  = 16,
  parameter int NUM_OBJECTS = 64,
  parameter int NUM_DEVICES = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  wmv_cfg_if   cfg_i,
  wmv_in_if    obs_i,
  wmv_out_if   vote_i,
  output int   n_errors_o,
  output int   n_waiting_o
);

  localparam int NUM_PAIRS = NUM_DEVICES * NUM_OBJECTS;

  logic [wmv_pkg::WSIZE_W-1:0] window_reg;
  logic                        pair_live [NUM_PAIRS];
  logic [wmv_pkg::LVL_W-1:0]   ring      [NUM_PAIRS][MAX_WINDOW];
  int                          ring_pos  [NUM_PAIRS];
  int                          ring_fill [NUM_PAIRS];
  logic [wmv_pkg::LVL_W-1:0]   voted_levels_q [$];
  logic [wmv_pkg::LVL_W-1:0]   exp_vote;

  // Stores one observation in its pair's ring and returns the mode of the
  // entries that the current window covers.
  function automatic logic [wmv_pkg::LVL_W-1:0] predict_vote(
      logic [wmv_pkg::DEV_W-1:0] dev,
      logic [wmv_pkg::OBJ_W-1:0] obj,
      logic [wmv_pkg::LVL_W-1:0] lvl);
    int win;
    int pair;
    int pos;
    int n;
    int best;
    int tally [NUM_LEVELS];
    win = int'(window_reg);
    if (win < 1) win = 1;
    if (win > MAX_WINDOW) win = MAX_WINDOW;
    pair = (int'(dev) % NUM_DEVICES) * NUM_OBJECTS + int'(obj) % NUM_OBJECTS;
    if (int'(lvl) >= NUM_LEVELS) lvl = wmv_pkg::LVL_W'(NUM_LEVELS - 1);
    if (!pair_live[pair]) begin
      pair_live[pair] = 1'b1;
      ring_pos[pair]  = 0;
      ring_fill[pair] = 0;
    end
    // A write position left beyond a shrunken window restarts at the front.
    pos = (ring_pos[pair] >= win) ? 0 : ring_pos[pair];
    ring[pair][pos] = lvl;
    pos = pos + 1;
    ring_pos[pair] = (pos >= win) ? 0 : pos;
    if (ring_fill[pair] < win) ring_fill[pair] = ring_fill[pair] + 1;
    n = (ring_fill[pair] < win) ? ring_fill[pair] : win;
    for (int i = 0; i < NUM_LEVELS; i++) tally[i] = 0;
    for (int i = 0; i < n; i++) tally[ring[pair][i]] = tally[ring[pair][i]] + 1;
    best = 0;
    for (int i = 1; i < NUM_LEVELS; i++) begin
      if (tally[i] > tally[best]) best = i;
    end
    return wmv_pkg::LVL_W'(best);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_reg = wmv_pkg::WSIZE_RST;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pair_live[p] = 1'b0;
        ring_pos[p]  = 0;
        ring_fill[p] = 0;
      end
      voted_levels_q.delete();
      n_errors_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) window_reg = cfg_i.window_size;
      if (obs_i.valid && obs_i.ready) begin
        exp_vote = predict_vote(obs_i.device_index, obs_i.object_slot,
                                obs_i.predicted_level);
        voted_levels_q = {voted_levels_q, exp_vote};
      end
      if (vote_i.valid && vote_i.ready) begin
        if (voted_levels_q.size() == 0) begin
          $display("%0t: vote transfer with no observation pending: actual %0d",
                   $time, vote_i.voted_level);
          n_errors_o = n_errors_o + 1;
        end else if (vote_i.voted_level !== voted_levels_q[0]) begin
          $display("%0t: voted_level mismatch: expected %0d, actual %0d",
                   $time, voted_levels_q[0], vote_i.voted_level);
          n_errors_o = n_errors_o + 1;
          void'(voted_levels_q.pop_front());
        end else begin
          void'(voted_levels_q.pop_front());
        end
      end
    end
    n_waiting_o = voted_levels_q.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the windowed majority vote block. A directed set of
// observations covers field extremes, out-of-range levels, ties and ring
// wrap; random phases run under several window settings, including zero
// and values above the maximum, most with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_LEVELS  = 5;
  localparam int MAX_WINDOW  = 16;
  localparam int NUM_OBJECTS = 64;
  localparam int NUM_DEVICES = 2;
  localparam int NUM_PAIRS   = NUM_DEVICES * NUM_OBJECTS;
  localparam int LIMIT       = 400000;
  localparam int N_DIRECTED  = 19;
  localparam int DEV_W       = wmv_pkg::DEV_W;
  localparam int OBJ_W       = wmv_pkg::OBJ_W;
  localparam int LVL_W       = wmv_pkg::LVL_W;
  localparam int WSIZE_W     = wmv_pkg::WSIZE_W;

  // Each entry is {device, object, level}.
  localparam logic [DEV_W+OBJ_W+LVL_W-1:0] DIRECTED [N_DIRECTED] = '{
    {1'b0, 6'd0, 3'd0}, {1'b1, 6'd63, 3'd4}, {1'b0, 6'd63, 3'd7},
    {1'b1, 6'd0, 3'd5}, {1'b1, 6'd0, 3'd6},
    {1'b0, 6'd1, 3'd3}, {1'b0, 6'd1, 3'd1}, {1'b0, 6'd1, 3'd1},
    {1'b0, 6'd1, 3'd3}, {1'b0, 6'd1, 3'd3}, {1'b0, 6'd1, 3'd3},
    {1'b1, 6'd42, 3'd2}, {1'b1, 6'd42, 3'd2}, {1'b1, 6'd42, 3'd0},
    {1'b1, 6'd42, 3'd0}, {1'b1, 6'd42, 3'd0},
    {1'b0, 6'd21, 3'd2}, {1'b0, 6'd21, 3'd4}, {1'b1, 6'd21, 3'd7}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  wmv_cfg_if cfg_ch ();
  wmv_in_if  obs_ch ();
  wmv_out_if vote_ch ();

  int n_errors;
  int n_waiting;
  int n_obs_sent;
  int n_votes_seen = 0;
  int n_settings;
  int snd_idle;
  int rcv_idle;
  logic [WSIZE_W-1:0] cur_win;

  // Ring occupancy per pair, kept only so that no vote ever covers an entry
  // that was never written.
  bit                  pair_used      [NUM_PAIRS];
  int                  shadow_pos     [NUM_PAIRS];
  int                  shadow_fill    [NUM_PAIRS];
  bit [MAX_WINDOW-1:0] shadow_written [NUM_PAIRS];
  int                  hot_pairs      [6];
  int                  n_hot;
  logic [LVL_W-1:0]    fav_level;

  windowed_majority_vote_per_object #(
    .NUM_LEVELS (NUM_LEVELS),
    .MAX_WINDOW (MAX_WINDOW),
    .NUM_OBJECTS(NUM_OBJECTS),
    .NUM_DEVICES(NUM_DEVICES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (obs_ch),
    .out_o (vote_ch)
  );

  mode_filter_checker #(
    .NUM_LEVELS (NUM_LEVELS),
    .MAX_WINDOW (MAX_WINDOW),
    .NUM_OBJECTS(NUM_OBJECTS),
    .NUM_DEVICES(NUM_DEVICES)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_ch),
    .obs_i      (obs_ch),
    .vote_i     (vote_ch),
    .n_errors_o (n_errors),
    .n_waiting_o(n_waiting)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    vote_ch.ready <= ($urandom_range(99) >= rcv_idle);
    if (vote_ch.valid && vote_ch.ready) n_votes_seen <= n_votes_seen + 1;
  end

  function automatic int eff_window();
    if (cur_win < 1) return 1;
    if (cur_win > MAX_WINDOW) return MAX_WINDOW;
    return int'(cur_win);
  endfunction

  function automatic bit pair_ok(int p);
    int w;
    int pos;
    int f;
    int n;
    if (!pair_used[p]) return 1'b1;
    w = eff_window();
    pos = (shadow_pos[p] >= w) ? 0 : shadow_pos[p];
    f = (shadow_fill[p] < w) ? shadow_fill[p] + 1 : shadow_fill[p];
    n = (f < w) ? f : w;
    for (int i = 0; i < n; i++) begin
      if (i != pos && !shadow_written[p][i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void pair_note(int p);
    int w;
    int pos;
    w = eff_window();
    if (!pair_used[p]) begin
      pair_used[p]   = 1'b1;
      shadow_pos[p]  = 0;
      shadow_fill[p] = 0;
    end
    pos = (shadow_pos[p] >= w) ? 0 : shadow_pos[p];
    shadow_written[p][pos] = 1'b1;
    shadow_pos[p] = (pos + 1 >= w) ? 0 : pos + 1;
    if (shadow_fill[p] < w) shadow_fill[p] = shadow_fill[p] + 1;
  endfunction

  function automatic int find_safe_pair();
    int start;
    start = $urandom_range(NUM_PAIRS - 1);
    for (int k = 0; k < NUM_PAIRS; k++) begin
      if (pair_ok((start + k) % NUM_PAIRS)) return (start + k) % NUM_PAIRS;
    end
    return -1;
  endfunction

  task automatic send_obs(logic [DEV_W-1:0] dev, logic [OBJ_W-1:0] obj,
                          logic [LVL_W-1:0] lvl);
    while ($urandom_range(99) < snd_idle) begin
      obs_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    obs_ch.valid           <= 1'b1;
    obs_ch.device_index    <= dev;
    obs_ch.object_slot     <= obj;
    obs_ch.predicted_level <= lvl;
    pair_note(int'(dev) * NUM_OBJECTS + int'(obj));
    @(posedge clk_i);
    while (obs_ch.ready !== 1'b1) @(posedge clk_i);
    n_obs_sent = n_obs_sent + 1;
  endtask

  // Holds the observation channel until every vote is back.
  task automatic drain_votes();
    obs_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (n_votes_seen != n_obs_sent) @(posedge clk_i);
  endtask

  task automatic write_window(logic [WSIZE_W-1:0] raw);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= raw;
    @(posedge clk_i);
    while (cfg_ch.ready !== 1'b1) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    cur_win    = raw;
    n_settings = n_settings + 1;
  endtask

  // Most observations go to a few pairs so that rings fill and wrap; the
  // rest land anywhere. Pairs whose next vote would cover an unwritten entry
  // are swapped for a legal one.
  task automatic random_batch(int count);
    int p;
    logic [LVL_W-1:0] lvl;
    n_hot = (eff_window() > 8) ? 3 : 6;
    for (int i = 0; i < n_hot; i++) hot_pairs[i] = find_safe_pair();
    fav_level = LVL_W'($urandom_range(NUM_LEVELS - 1));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 85) p = hot_pairs[$urandom_range(n_hot - 1)];
      else p = $urandom_range(NUM_PAIRS - 1);
      if (p < 0 || !pair_ok(p)) p = find_safe_pair();
      if (p >= 0) begin
        lvl = $urandom_range(1) ? fav_level : LVL_W'($urandom_range(7));
        send_obs(DEV_W'(p / NUM_OBJECTS), OBJ_W'(p % NUM_OBJECTS), lvl);
      end
    end
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles = cycles + 1;
    end
    $display("%0t: run exceeded %0d cycles", $time, LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int touched;
    rst_ni                 <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.window_size     <= '0;
    obs_ch.valid           <= 1'b0;
    obs_ch.device_index    <= '0;
    obs_ch.object_slot     <= '0;
    obs_ch.predicted_level <= '0;
    n_obs_sent   = 0;
    n_settings   = 1;
    cur_win      = wmv_pkg::WSIZE_RST;
    snd_idle     = 29;
    rcv_idle     = 82;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_obs(DIRECTED[i][DEV_W+OBJ_W+LVL_W-1 -: DEV_W],
               DIRECTED[i][OBJ_W+LVL_W-1 -: OBJ_W], DIRECTED[i][LVL_W-1:0]);
    end
    random_batch(45);
    drain_votes();

    // Shrinking the window under rings that are in use.
    write_window(5'd2);
    send_obs(1'b0, 6'd1, 3'd0);
    send_obs(1'b1, 6'd42, 3'd4);
    random_batch(40);
    drain_votes();
    write_window(5'd0);
    random_batch(40);
    drain_votes();

    snd_idle = 82;
    rcv_idle = 29;
    write_window(5'd31);
    random_batch(60);
    drain_votes();
    write_window(5'd16);
    random_batch(50);
    drain_votes();
    write_window(5'd1);
    random_batch(30);
    drain_votes();

    snd_idle = 0;
    rcv_idle = 0;
    repeat (3) begin
      write_window(WSIZE_W'($urandom_range(31)));
      random_batch(40);
      drain_votes();
    end
    repeat (40) @(posedge clk_i);

    touched = 0;
    for (int p = 0; p < NUM_PAIRS; p++) touched = touched + pair_used[p];
    $display("Ran %0d observations over %0d window settings, touching %0d object histories,",
             n_obs_sent, n_settings, touched);
    $display("with stalls on each channel in turn and a final stretch at full rate.");
    if (n_waiting != 0) begin
      $display("%0t: %0d predicted votes never arrived", $time, n_waiting);
    end
    if (n_errors == 0 && n_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
